// ===== design/mprot_pkg.sv =====
package mprot_pkg;

    // motor states, encoded as reported on the result channel
    typedef enum logic [1:0] {
        ST_STOP  = 2'd0,
        ST_RUN   = 2'd1,
        ST_WARN  = 2'd2,
        ST_FAULT = 2'd3
    } t_state;

    // fault event codes
    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_OVERHEAT = 2'd1,
        EV_OVERCUR  = 2'd2,
        EV_TEMPWARN = 2'd3
    } t_event;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_TEMP_WARN  = 2'd0,
        CFG_TEMP_FAULT = 2'd1,
        CFG_CUR_LIMIT  = 2'd2,
        CFG_TEMP_HYST  = 2'd3
    } t_cfg_index;

    localparam int unsigned CFG_DATA_W = 15;

    // reset values of the configuration registers
    localparam logic [10:0] RST_TEMP_WARN  = 11'd450;
    localparam logic [10:0] RST_TEMP_FAULT = 11'd650;
    localparam logic [14:0] RST_CUR_LIMIT  = 15'd2000;
    localparam logic [8:0]  RST_TEMP_HYST  = 9'd50;

    // automatic duty table breakpoints and levels
    localparam logic signed [11:0] AUTO_T0 = 12'sd350;
    localparam logic signed [11:0] AUTO_T1 = 12'sd450;
    localparam logic signed [11:0] AUTO_T2 = 12'sd550;
    localparam logic [6:0] DUTY_LOW  = 7'd40;
    localparam logic [6:0] DUTY_MID  = 7'd70;
    localparam logic [6:0] DUTY_MAX  = 7'd100;

    // one input transaction
    typedef struct packed {
        logic signed [11:0] temperature;
        logic               temp_error;
        logic               voltage_error;
        logic signed [15:0] current_ma;
        logic               current_error;
        logic               enable;
        logic [7:0]         duty_setpoint;
        logic               mode;
        logic               reset_fault;
    } t_item;

    // threshold configuration
    typedef struct packed {
        logic [10:0] temp_warn;
        logic [10:0] temp_fault;
        logic [14:0] cur_limit;
        logic [8:0]  temp_hyst;
    } t_cfg;

    // state machine results handed to the duty logic and the output register
    typedef struct packed {
        t_state             state;
        logic signed [11:0] temp_used;
        t_event             event_code;
        logic               rejected;
        logic [2:0]         errors;
    } t_fsm_res;

endpackage

// ===== design/motor_protection_fsm_pwm.sv =====
// Motor protection state machine with PWM duty output.
// Input channel (i_in_valid / o_in_ready) carries one control tick: the
// temperature and current readings with their error flags, the operator
// enable, setpoint, mode and fault reset request. Output channel
// (o_out_valid / i_out_ready) returns one result per tick: motor state,
// applied duty, timer compare value, lamp, buzzer, fault event, sensor
// error flags and the fault-reset refusal flag.
// Thresholds are written through i_cfg_we / i_cfg_index / i_cfg_wdata; the
// user must do so only while the block holds no transaction, which the
// block itself does not enforce. An accepted transaction is loaded into
// the input register, and the state machine and duty logic then load the
// result register from it, when o_out_valid rises. Throughput is one
// transaction per cycle while the receiver does not stall; the state
// update and the result register load happen in the same cycle.
// When the receiver stalls, the result holds and the input register keeps
// one more transaction; o_in_ready drops only while both are full.
// Synchronous reset puts the motor in STOP, clears the stored readings,
// restores the default thresholds and empties both registers.
module motor_protection_fsm_pwm import mprot_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [11:0]    i_temperature,
    input  logic                  i_temp_error,
    input  logic                  i_voltage_error,
    input  logic signed [15:0]    i_current_ma,
    input  logic                  i_current_error,
    input  logic                  i_enable,
    input  logic [7:0]            i_duty_setpoint,
    input  logic                  i_mode,
    input  logic                  i_reset_fault,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_motor_state,
    output logic [6:0]            o_duty_percent,
    output logic [6:0]            o_pwm_compare,
    output logic                  o_led_on,
    output logic                  o_buzzer_on,
    output logic [1:0]            o_fault_event,
    output logic [2:0]            o_sensor_errors,
    output logic                  o_reset_rejected
);

    t_cfg       r_cfg;
    t_item      r_in;
    logic       r_in_valid;
    logic       r_out_valid;
    logic [1:0] r_motor_state;
    logic [6:0] r_duty;
    logic [6:0] r_compare;
    logic       r_led;
    logic       r_buzzer;
    logic [1:0] r_event;
    logic [2:0] r_errors;
    logic       r_rejected;

    logic       adv;
    logic       in_take;
    t_fsm_res   fsm_res;
    logic [6:0] duty;
    logic [6:0] compare;
    logic       led;
    logic       buzzer;

    // handshake control
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign in_take    = i_in_valid && o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_warn  <= RST_TEMP_WARN;
            r_cfg.temp_fault <= RST_TEMP_FAULT;
            r_cfg.cur_limit  <= RST_CUR_LIMIT;
            r_cfg.temp_hyst  <= RST_TEMP_HYST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TEMP_WARN:  r_cfg.temp_warn  <= i_cfg_wdata[10:0];
                CFG_TEMP_FAULT: r_cfg.temp_fault <= i_cfg_wdata[10:0];
                CFG_CUR_LIMIT:  r_cfg.cur_limit  <= i_cfg_wdata[14:0];
                CFG_TEMP_HYST:  r_cfg.temp_hyst  <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.temperature   <= i_temperature;
            r_in.temp_error    <= i_temp_error;
            r_in.voltage_error <= i_voltage_error;
            r_in.current_ma    <= i_current_ma;
            r_in.current_error <= i_current_error;
            r_in.enable        <= i_enable;
            r_in.duty_setpoint <= i_duty_setpoint;
            r_in.mode          <= i_mode;
            r_in.reset_fault   <= i_reset_fault;
        end
    end

    // state machine with stored readings
    mprot_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (fsm_res)
    );

    // duty and indicator logic
    mprot_duty u_duty (
        .i_state    (fsm_res.state),
        .i_temp     (fsm_res.temp_used),
        .i_setpoint (r_in.duty_setpoint),
        .i_mode     (r_in.mode),
        .o_duty     (duty),
        .o_compare  (compare),
        .o_led      (led),
        .o_buzzer   (buzzer)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_motor_state <= fsm_res.state;
            r_duty        <= duty;
            r_compare     <= compare;
            r_led         <= led;
            r_buzzer      <= buzzer;
            r_event       <= fsm_res.event_code;
            r_errors      <= fsm_res.errors;
            r_rejected    <= fsm_res.rejected;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_motor_state    = r_motor_state;
    assign o_duty_percent   = r_duty;
    assign o_pwm_compare    = r_compare;
    assign o_led_on         = r_led;
    assign o_buzzer_on      = r_buzzer;
    assign o_fault_event    = r_event;
    assign o_sensor_errors  = r_errors;
    assign o_reset_rejected = r_rejected;

    // a refused reset leaves the motor in fault
    a_reject_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reset_rejected |-> o_motor_state == ST_FAULT)
        else $error("reset refused outside fault state");

    // nonzero duty only while the run lamp is on
    a_duty_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_duty_percent != 7'd0) |-> o_led_on)
        else $error("duty applied with motor not running");

    // input backpressure only when the result is stalled
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

    // compare value tracks the duty
    a_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pwm_compare <= o_duty_percent) && (o_duty_percent <= 7'd100))
        else $error("compare value out of range");

endmodule

// ===== design/mprot_fsm.sv =====
module mprot_fsm import mprot_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  t_item    i_item,
    input  t_cfg     i_cfg,
    output t_fsm_res o_res
);

    t_state             r_state;
    t_state             n_state;
    logic signed [11:0] r_last_temp;
    logic signed [15:0] r_last_cur;

    logic signed [11:0] temp_used;
    logic signed [15:0] cur_used;
    logic [2:0]         errors;
    t_state             st_eff;
    logic               rst_ok;
    logic               over_temp;
    logic               over_cur;
    logic               above_warn;
    logic               below_hyst;
    logic signed [12:0] hyst_level;
    t_event             event_code;

    // failed readings fall back to the stored value
    assign temp_used = i_item.temp_error    ? r_last_temp : i_item.temperature;
    assign cur_used  = i_item.current_error ? r_last_cur  : i_item.current_ma;
    assign errors    = {i_item.current_error, i_item.voltage_error, i_item.temp_error};

    // fault reset only with all sensors healthy
    assign rst_ok = i_item.reset_fault && (r_state == ST_FAULT) && (errors == 3'd0);
    assign st_eff = rst_ok ? ST_STOP : r_state;

    // threshold compares
    assign hyst_level = $signed({2'b00, i_cfg.temp_warn}) - $signed({4'b0000, i_cfg.temp_hyst});
    assign over_temp  = $signed({temp_used[11], temp_used}) > $signed({2'b00, i_cfg.temp_fault});
    assign over_cur   = $signed({cur_used[15], cur_used}) > $signed({2'b00, i_cfg.cur_limit});
    assign above_warn = $signed({temp_used[11], temp_used}) > $signed({2'b00, i_cfg.temp_warn});
    assign below_hyst = $signed({temp_used[11], temp_used}) < hyst_level;

    // next state
    always_comb begin
        n_state = st_eff;
        unique case (st_eff)
            ST_STOP: begin
                if (i_item.enable && (i_item.duty_setpoint != 8'd0) &&
                    !(i_item.temp_error && (i_item.voltage_error || i_item.current_error))) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN, ST_WARN: begin
                if (!i_item.enable) begin
                    n_state = ST_STOP;
                end else if (over_temp || over_cur) begin
                    n_state = ST_FAULT;
                end else if ((st_eff == ST_RUN) && above_warn) begin
                    n_state = ST_WARN;
                end else if ((st_eff == ST_WARN) && below_hyst) begin
                    n_state = ST_RUN;
                end
            end
            ST_FAULT: begin
                n_state = ST_FAULT;
            end
            default: begin
                n_state = ST_STOP;
            end
        endcase
    end

    // event report, independent of the enable override
    always_comb begin
        event_code = EV_NONE;
        unique case (st_eff)
            ST_RUN, ST_WARN: begin
                if (over_temp) begin
                    event_code = EV_OVERHEAT;
                end else if (over_cur) begin
                    event_code = EV_OVERCUR;
                end else if ((st_eff == ST_RUN) && above_warn) begin
                    event_code = EV_TEMPWARN;
                end
            end
            default: begin
                event_code = EV_NONE;
            end
        endcase
    end

    assign o_res.state      = n_state;
    assign o_res.temp_used  = temp_used;
    assign o_res.event_code = event_code;
    assign o_res.rejected   = i_item.reset_fault && (r_state == ST_FAULT) && (errors != 3'd0);
    assign o_res.errors     = errors;

    // state and last readings advance once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_STOP;
            r_last_temp <= '0;
            r_last_cur  <= '0;
        end else if (i_adv) begin
            r_state     <= n_state;
            r_last_temp <= temp_used;
            r_last_cur  <= cur_used;
        end
    end

endmodule

// ===== design/mprot_duty.sv =====
module mprot_duty import mprot_pkg::*; (
    input  t_state             i_state,
    input  logic signed [11:0] i_temp,
    input  logic [7:0]         i_setpoint,
    input  logic               i_mode,
    output logic [6:0]         o_duty,
    output logic [6:0]         o_compare,
    output logic               o_led,
    output logic               o_buzzer
);

    logic [6:0] base;
    logic [6:0] manual;

    // manual setpoint saturates at full duty
    assign manual = (i_setpoint > {1'b0, DUTY_MAX}) ? DUTY_MAX : i_setpoint[6:0];

    // base duty from table or setpoint
    always_comb begin
        if (i_mode) begin
            if (i_temp < AUTO_T0) begin
                base = 7'd0;
            end else if (i_temp < AUTO_T1) begin
                base = DUTY_LOW;
            end else if (i_temp < AUTO_T2) begin
                base = DUTY_MID;
            end else begin
                base = DUTY_MAX;
            end
        end else begin
            base = manual;
        end
    end

    // duty by state, halved in warning
    always_comb begin
        case (i_state)
            ST_RUN:  o_duty = base;
            ST_WARN: o_duty = {1'b0, base[6:1]};
            default: o_duty = 7'd0;
        endcase
    end

    // duty*99/100 is duty-1 for any nonzero duty up to 100
    assign o_compare = (o_duty == 7'd0) ? 7'd0 : o_duty - 7'd1;
    assign o_led     = (i_state == ST_RUN) || (i_state == ST_WARN);
    assign o_buzzer  = (i_state == ST_WARN) || (i_state == ST_FAULT);

endmodule

// ===== sim/motor_protection_fsm_pwm_tb.sv =====
module motor_protection_fsm_pwm_tb;
    import mprot_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one result transaction as seen on the output ports
    typedef struct packed {
        logic [1:0] state;
        logic [6:0] duty;
        logic [6:0] compare;
        logic       led;
        logic       buzzer;
        logic [1:0] event_code;
        logic [2:0] errors;
        logic       rejected;
    } t_motor_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [1:0]            i_cfg_index = 2'd0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_item                 tick_drv = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [1:0]            o_motor_state;
    logic [6:0]            o_duty_percent;
    logic [6:0]            o_pwm_compare;
    logic                  o_led_on;
    logic                  o_buzzer_on;
    logic [1:0]            o_fault_event;
    logic [2:0]            o_sensor_errors;
    logic                  o_reset_rejected;

    // control ticks still to be offered and results still owed by the block
    t_item      ticks_waiting[$];
    t_motor_out motor_outs_due[$];

    // shadow of the block: thresholds, motor state and held readings
    t_cfg   cfg_shadow = '{temp_warn: RST_TEMP_WARN, temp_fault: RST_TEMP_FAULT,
                           cur_limit: RST_CUR_LIMIT, temp_hyst: RST_TEMP_HYST};
    t_state motor_st = ST_STOP;
    int     held_temp = 0;
    int     held_cur = 0;

    int mismatches = 0;
    int results_seen = 0;
    int send_gap = 0;
    int send_calm = 0;
    int recv_hold = 0;
    int recv_calm = 0;

    motor_protection_fsm_pwm dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_temperature   (tick_drv.temperature),
        .i_temp_error    (tick_drv.temp_error),
        .i_voltage_error (tick_drv.voltage_error),
        .i_current_ma    (tick_drv.current_ma),
        .i_current_error (tick_drv.current_error),
        .i_enable        (tick_drv.enable),
        .i_duty_setpoint (tick_drv.duty_setpoint),
        .i_mode          (tick_drv.mode),
        .i_reset_fault   (tick_drv.reset_fault),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_motor_state   (o_motor_state),
        .o_duty_percent  (o_duty_percent),
        .o_pwm_compare   (o_pwm_compare),
        .o_led_on        (o_led_on),
        .o_buzzer_on     (o_buzzer_on),
        .o_fault_event   (o_fault_event),
        .o_sensor_errors (o_sensor_errors),
        .o_reset_rejected(o_reset_rejected)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // advance the shadow by one control tick and queue the result it owes
    task automatic motor_tick(input t_item it);
        int         temp_v;
        int         cur_v;
        int         base;
        int         duty;
        t_state     st;
        t_state     nxt;
        t_event     ev;
        logic       rej;
        logic [2:0] errs;
        t_motor_out res;

        errs = {it.current_error, it.voltage_error, it.temp_error};
        // failed readings fall back to the held value
        temp_v = it.temp_error ? held_temp : int'($signed(it.temperature));
        cur_v = it.current_error ? held_cur : int'($signed(it.current_ma));
        held_temp = temp_v;
        held_cur = cur_v;
        ev = EV_NONE;
        rej = 1'b0;

        // fault reset only with all readings healthy
        st = motor_st;
        if (it.reset_fault && st == ST_FAULT) begin
            if (errs == 3'b000) st = ST_STOP;
            else rej = 1'b1;
        end

        nxt = st;
        case (st)
            ST_STOP: begin
                if (it.enable && it.duty_setpoint != 8'd0 &&
                    !(it.temp_error && (it.voltage_error || it.current_error)))
                    nxt = ST_RUN;
            end
            ST_RUN, ST_WARN: begin
                if (temp_v > int'(cfg_shadow.temp_fault)) begin
                    nxt = ST_FAULT;
                    ev = EV_OVERHEAT;
                end else if (cur_v > int'(cfg_shadow.cur_limit)) begin
                    nxt = ST_FAULT;
                    ev = EV_OVERCUR;
                end else if (st == ST_RUN) begin
                    if (temp_v > int'(cfg_shadow.temp_warn)) begin
                        nxt = ST_WARN;
                        ev = EV_TEMPWARN;
                    end
                end else if (temp_v < int'(cfg_shadow.temp_warn) -
                                      int'(cfg_shadow.temp_hyst)) begin
                    nxt = ST_RUN;
                end
                // disable wins over any fault seen this tick
                if (!it.enable) nxt = ST_STOP;
            end
            default: ;
        endcase
        motor_st = nxt;

        // duty source: temperature table or saturated setpoint
        if (it.mode) begin
            if (temp_v < int'(AUTO_T0)) base = 0;
            else if (temp_v < int'(AUTO_T1)) base = int'(DUTY_LOW);
            else if (temp_v < int'(AUTO_T2)) base = int'(DUTY_MID);
            else base = int'(DUTY_MAX);
        end else begin
            base = (it.duty_setpoint > 8'd100) ? 100 : int'(it.duty_setpoint);
        end
        if (nxt == ST_RUN) duty = base;
        else if (nxt == ST_WARN) duty = (base * 50) / 100;
        else duty = 0;

        res.state = nxt;
        res.duty = 7'(duty);
        res.compare = 7'((duty * 99) / 100);
        res.led = (nxt == ST_RUN || nxt == ST_WARN);
        res.buzzer = (nxt == ST_WARN || nxt == ST_FAULT);
        res.event_code = ev;
        res.errors = errs;
        res.rejected = rej;
        motor_outs_due.push_back(res);
    endtask

    function automatic t_item make_tick(input int t, input bit te, input bit ve,
                                        input int c, input bit ce, input bit en,
                                        input int sp, input bit md, input bit rf);
        t_item it;
        it.temperature = 12'(t);
        it.temp_error = te;
        it.voltage_error = ve;
        it.current_ma = 16'(c);
        it.current_error = ce;
        it.enable = en;
        it.duty_setpoint = 8'(sp);
        it.mode = md;
        it.reset_fault = rf;
        return it;
    endfunction

    // random tick, readings clustered around the active thresholds
    function automatic t_item random_tick();
        int r;
        int t;
        int c;
        int sp;
        int lim;
        r = $urandom_range(0, 99);
        if (r < 45) t = int'(cfg_shadow.temp_warn) + int'($urandom_range(0, 160)) - 80;
        else if (r < 65) t = int'(cfg_shadow.temp_fault) + int'($urandom_range(0, 40)) - 20;
        else if (r < 92) t = int'($urandom_range(0, 2050)) - 550;
        else t = int'($urandom_range(0, 4095)) - 2048;
        if (t > 2047) t = 2047;
        if (t < -2048) t = -2048;

        lim = int'(cfg_shadow.cur_limit);
        r = $urandom_range(0, 99);
        if (r < 70) c = int'($urandom_range(0, lim + 200)) - 100;
        else if (r < 85) c = lim + int'($urandom_range(0, 40)) - 20;
        else c = int'($urandom_range(0, 65535)) - 32768;
        if (c > 32767) c = 32767;

        r = $urandom_range(0, 99);
        if (r < 8) sp = 0;
        else if (r < 25) sp = $urandom_range(101, 255);
        else sp = $urandom_range(1, 100);

        return make_tick(t, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                         c, $urandom_range(0, 9) == 0, $urandom_range(0, 11) != 0,
                         sp, $urandom_range(0, 1), $urandom_range(0, 4) == 0);
    endfunction

    task automatic queue_random(input int n);
        repeat (n) ticks_waiting.push_back(random_tick());
    endtask

    task automatic write_reg(input t_cfg_index idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_thresholds(input int unsigned warn, input int unsigned fault,
                                  input int unsigned limit, input int unsigned hyst);
        write_reg(CFG_TEMP_WARN, warn);
        write_reg(CFG_TEMP_FAULT, fault);
        write_reg(CFG_CUR_LIMIT, limit);
        write_reg(CFG_TEMP_HYST, hyst);
        cfg_shadow.temp_warn = warn[10:0];
        cfg_shadow.temp_fault = fault[10:0];
        cfg_shadow.cur_limit = limit[14:0];
        cfg_shadow.temp_hyst = hyst[8:0];
        @(negedge i_clk);
    endtask

    // block holds nothing: all ticks sent and all results returned
    task automatic wait_idle();
        while (ticks_waiting.size() != 0 || i_in_valid || motor_outs_due.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) motor_tick(tick_drv);
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (ticks_waiting.size() != 0) begin
                tick_drv <= ticks_waiting.pop_front();
                i_in_valid <= 1'b1;
                if (send_calm > 0) begin
                    send_calm = send_calm - 1;
                end else begin
                    send_gap = pick_gap();
                    if ($urandom_range(0, 19) == 0) send_calm = 40;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_motor_out got;
        t_motor_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = {o_motor_state, o_duty_percent, o_pwm_compare, o_led_on,
                       o_buzzer_on, o_fault_event, o_sensor_errors, o_reset_rejected};
                results_seen = results_seen + 1;
                if (motor_outs_due.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t: unexpected result transaction, state=%0d duty=%0d",
                             $time, got.state, got.duty);
                end else begin
                    want = motor_outs_due.pop_front();
                    if (got !== want) begin
                        mismatches = mismatches + 1;
                        $display({"%0t: result mismatch, expected state=%0d duty=%0d ",
                                  "cmp=%0d led=%0b buz=%0b ev=%0d err=%b rej=%0b, actual ",
                                  "state=%0d duty=%0d cmp=%0d led=%0b buz=%0b ev=%0d ",
                                  "err=%b rej=%0b"}, $time,
                                 want.state, want.duty, want.compare, want.led,
                                 want.buzzer, want.event_code, want.errors, want.rejected,
                                 got.state, got.duty, got.compare, got.led,
                                 got.buzzer, got.event_code, got.errors, got.rejected);
                    end
                end
                // long back-pressure so the block fills and stalls its input
                if (results_seen == 150 || results_seen == 480) recv_hold = 80;
            end
            if (recv_hold > 0) begin
                recv_hold = recv_hold - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (recv_calm > 0) recv_calm = recv_calm - 1;
                else if ($urandom_range(0, 3) == 0) recv_hold = pick_gap();
                else if ($urandom_range(0, 49) == 0) recv_calm = 50;
            end
        end
    end

    // stimulus sequence
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed ticks with the reset thresholds
        ticks_waiting.push_back(make_tick(200, 0, 0, 100, 0, 1, 0, 0, 0));
        ticks_waiting.push_back(make_tick(200, 0, 0, 100, 0, 1, 255, 0, 0));
        ticks_waiting.push_back(make_tick(460, 0, 0, 100, 0, 1, 80, 0, 0));
        ticks_waiting.push_back(make_tick(420, 0, 0, 100, 0, 1, 80, 0, 0));
        ticks_waiting.push_back(make_tick(399, 0, 0, 100, 0, 1, 80, 1, 0));
        ticks_waiting.push_back(make_tick(651, 0, 0, 100, 0, 1, 80, 0, 0));
        ticks_waiting.push_back(make_tick(300, 1, 0, 100, 0, 1, 80, 0, 1));
        ticks_waiting.push_back(make_tick(300, 0, 0, 100, 0, 1, 101, 0, 1));
        ticks_waiting.push_back(make_tick(300, 0, 0, 2001, 0, 1, 50, 0, 0));
        ticks_waiting.push_back(make_tick(300, 0, 0, 100, 0, 0, 50, 0, 1));
        ticks_waiting.push_back(make_tick(1500, 1, 1, 100, 0, 1, 50, 0, 0));
        ticks_waiting.push_back(make_tick(-550, 1, 0, -32768, 1, 1, 50, 0, 0));
        ticks_waiting.push_back(make_tick(-550, 1, 0, 100, 0, 1, 50, 0, 0));
        ticks_waiting.push_back(make_tick(700, 0, 0, 100, 0, 0, 50, 0, 0));
        ticks_waiting.push_back(make_tick(100, 0, 0, 100, 0, 1, 1, 0, 1));
        ticks_waiting.push_back(make_tick(349, 0, 0, 32767, 1, 1, 1, 1, 0));
        ticks_waiting.push_back(make_tick(350, 0, 0, 0, 0, 1, 1, 1, 0));
        ticks_waiting.push_back(make_tick(449, 0, 0, 0, 0, 1, 1, 1, 0));
        ticks_waiting.push_back(make_tick(450, 0, 0, 0, 0, 1, 1, 1, 0));
        ticks_waiting.push_back(make_tick(550, 0, 0, 0, 0, 1, 1, 1, 0));
        ticks_waiting.push_back(make_tick(2047, 0, 0, 0, 0, 1, 1, 1, 0));
        ticks_waiting.push_back(make_tick(-2048, 0, 1, 0, 0, 1, 255, 1, 1));
        ticks_waiting.push_back(make_tick(-2048, 0, 0, 0, 1, 1, 255, 1, 1));
        ticks_waiting.push_back(make_tick(-2048, 0, 0, 0, 0, 1, 255, 1, 1));
        ticks_waiting.push_back(make_tick(600, 0, 0, 32767, 0, 1, 255, 0, 0));
        queue_random(100);
        wait_idle();

        // upper extremes, then all zero
        set_thresholds(1500, 1500, 32767, 500);
        queue_random(110);
        wait_idle();
        set_thresholds(0, 0, 0, 0);
        queue_random(90);
        wait_idle();

        // plausible random thresholds, then fully random ones
        set_thresholds($urandom_range(250, 700), $urandom_range(700, 1100),
                       $urandom_range(500, 5000), $urandom_range(0, 200));
        queue_random(110);
        wait_idle();
        set_thresholds($urandom_range(0, 1500), $urandom_range(0, 1500),
                       $urandom_range(0, 32767), $urandom_range(0, 500));
        queue_random(110);
        wait_idle();

        // reset thresholds without hysteresis
        set_thresholds(450, 650, 2000, 0);
        queue_random(110);
        wait_idle();

        repeat (5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
